FILE: hdl/xxtea_pkg.sv
`default_nettype none

package xxtea_pkg;

    // Cipher geometry
    localparam int WordWidth     = 32;
    localparam int NumWords      = 4;
    localparam int WordIdxWidth  = $clog2(NumWords);
    localparam int NumRounds     = 19;
    localparam int NumStages     = NumRounds * NumWords;
    localparam int NumKeyWords   = 4;
    localparam int KeyIdxWidth   = $clog2(NumKeyWords);
    localparam int CfgIndexWidth = 8;

    localparam logic [WordWidth-1:0] Delta = 32'h9e37_79b9;

    typedef logic [WordWidth-1:0] word_t;
    typedef logic [NumWords-1:0][WordWidth-1:0] words_t;
    typedef logic [NumKeyWords-1:0][WordWidth-1:0] key_t;
    typedef logic [NumRounds:1][WordWidth-1:0] sum_tab_t;

    // Operation codes carried by the mode field
    typedef enum logic {
        MODE_ENCRYPT = 1'b0,
        MODE_DECRYPT = 1'b1
    } mode_t;

    // Input transaction
    typedef struct packed {
        logic  mode;
        word_t block_in0;
        word_t block_in1;
        word_t block_in2;
        word_t block_in3;
    } block_in_t;

    // Result transaction
    typedef struct packed {
        word_t block_out0;
        word_t block_out1;
        word_t block_out2;
        word_t block_out3;
    } block_out_t;

    // Round sums r * Delta mod 2^32, r = 1..NumRounds
    function automatic sum_tab_t build_round_sums();
        sum_tab_t    tab;
        logic [63:0] prod;
        for (int r = 1; r <= NumRounds; r++)
        begin
            prod   = 64'(r) * 64'(Delta);
            tab[r] = prod[WordWidth-1:0];
        end
        return tab;
    endfunction

    localparam sum_tab_t RoundSums = build_round_sums();

endpackage

`default_nettype wire

FILE: hdl/xxtea_block_cipher_128.sv
`default_nettype none

// XXTEA cipher on one 128-bit block (four 32-bit words) under a 128-bit key
// held in four key registers (index 0..3 on the cfg port; other indexes are
// dropped). Each block transaction carries a mode bit: 0 encrypts with 19
// rounds, 1 decrypts. The datapath is a 76-stage pipeline, one word update
// (mix value plus add or subtract) per stage, so a new block is accepted
// every cycle while the result is not stalled. A stalled result
// freezes the whole pipeline; nothing is dropped or repeated. Key writes
// take effect at once and are meant for when the pipeline is empty.
module xxtea_block_cipher_128 (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // block transactions in
    input  wire logic                                 block_valid,
    output      logic                                 block_stall,
    input  wire xxtea_pkg::block_in_t                 block,
    // result transactions out
    output      logic                                 result_valid,
    input  wire logic                                 result_stall,
    output      xxtea_pkg::block_out_t                result,
    // key register writes
    input  wire logic                                 cfg_valid,
    output      logic                                 cfg_ready,
    input  wire logic [xxtea_pkg::CfgIndexWidth-1:0]  cfg_index,
    input  wire logic [xxtea_pkg::WordWidth-1:0]      cfg_data
);
    import xxtea_pkg::*;

    key_t                   key_reg;
    logic [NumStages-1:0]   valid_reg;
    logic [NumStages-2:0]   mode_reg;
    words_t                 words_reg  [0:NumStages-1];
    words_t                 words_next [0:NumStages-1];
    words_t                 block_words;
    logic                   advance;

    // XXTEA mix value
    function automatic word_t mix(word_t y, word_t z, word_t sum, word_t kw);
        return (((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4))) ^
               ((sum ^ y) + (kw ^ z));
    endfunction

    // Key registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg_valid && (cfg_index < CfgIndexWidth'(NumKeyWords)))
        begin
            key_reg[cfg_index[KeyIdxWidth-1:0]] <= cfg_data;
        end
    end

    // Global pipeline advance: only a held result stops it
    assign advance      = !(valid_reg[NumStages-1] && result_stall);
    assign block_stall  = !advance;
    assign result_valid = valid_reg[NumStages-1];

    assign block_words[0] = block.block_in0;
    assign block_words[1] = block.block_in1;
    assign block_words[2] = block.block_in2;
    assign block_words[3] = block.block_in3;

    // One word update per stage
    for (genvar s = 0; s < NumStages; s++)
    begin : g_stage
        localparam int RoundEnc = s / NumWords + 1;
        localparam int RoundDec = NumRounds - s / NumWords;
        localparam int Pos      = s % NumWords;
        localparam logic [WordIdxWidth-1:0] PosEnc = WordIdxWidth'(Pos);
        localparam logic [WordIdxWidth-1:0] PosDec = WordIdxWidth'(NumWords - 1 - Pos);

        words_t                  w_in;
        logic                    mode_in;
        word_t                   sum;
        logic [WordIdxWidth-1:0] p;
        word_t                   m;

        if (s == 0)
        begin : g_first
            assign w_in    = block_words;
            assign mode_in = block.mode;
        end
        else
        begin : g_rest
            assign w_in    = words_reg[s-1];
            assign mode_in = mode_reg[s-1];
        end

        always_comb
        begin
            if (mode_in == MODE_DECRYPT)
            begin
                sum = RoundSums[RoundDec];
                p   = PosDec;
            end
            else
            begin
                sum = RoundSums[RoundEnc];
                p   = PosEnc;
            end
            m = mix(w_in[p + WordIdxWidth'(1)], w_in[p - WordIdxWidth'(1)], sum,
                    key_reg[p ^ sum[3:2]]);
            words_next[s] = w_in;
            if (mode_in == MODE_DECRYPT)
                words_next[s][p] = w_in[p] - m;
            else
                words_next[s][p] = w_in[p] + m;
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[NumStages-2:0], block_valid};
        end
    end

    // Payload stages; the last stage needs no mode bit
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mode_reg[0] <= block.mode;
            for (int s = 1; s < NumStages - 1; s++)
            begin
                mode_reg[s] <= mode_reg[s-1];
            end
            for (int s = 0; s < NumStages; s++)
            begin
                words_reg[s] <= words_next[s];
            end
        end
    end

    // Result transaction
    assign result.block_out0 = words_reg[NumStages-1][0];
    assign result.block_out1 = words_reg[NumStages-1][1];
    assign result.block_out2 = words_reg[NumStages-1][2];
    assign result.block_out3 = words_reg[NumStages-1][3];

endmodule

`default_nettype wire
